// ----- sv/paw_pkg.sv -----
// ----------------------------------------------------------------------------
// Piecewise affine warp package
// Shared types, codes and fixed-point helpers for the warp engine.
// ----------------------------------------------------------------------------
package paw_pkg;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_WARP    = 2'd1,
    OP_COMPOSE = 2'd2,
    OP_MAP     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_INV,
    ST_CALC_N,
    ST_RD_WARP,
    ST_CALC_W,
    ST_CALC_M,
    ST_WR_WARP,
    ST_DONE
  } state_t;

  localparam int ACC_W = 50;
  localparam int INV_ENTRIES = 9;
  localparam int WARP_ENTRIES = 6;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [31:0] q16_t;

  localparam q16_t Q16_ONE = 32'sd65536;
  localparam q16_t Q16_MAX = 32'sh7fffffff;
  localparam q16_t Q16_MIN = 32'sh80000000;

  typedef struct packed {
    logic mul;
    logic init;
    logic acc;
  } mac_ctrl_t;

  function automatic q16_t sat32(acc_t v);
    q16_t res;
    if (v > acc_t'(Q16_MAX)) begin
      res = Q16_MAX;
    end else if (v < acc_t'(Q16_MIN)) begin
      res = Q16_MIN;
    end else begin
      res = q16_t'(v);
    end
    return res;
  endfunction

  function automatic q16_t ident(logic [2:0] k);
    q16_t res;
    res = (k == 3'd0 || k == 3'd4) ? Q16_ONE : '0;
    return res;
  endfunction

endpackage

// ----- sv/piecewise_affine_warp_engine_top.sv -----
// ----------------------------------------------------------------------------
// Piecewise affine warp engine
// Per-triangle inverse matrices and affine warps in signed Q16.16.
// ----------------------------------------------------------------------------
// Each request is processed alone, and the input is stalled until its result
// has been taken. All products go through one shared multiplier with an
// accumulator, so the product count and the table reads set how long each
// request takes. Warps start as identity without a clearing pass.
module piecewise_affine_warp_engine_top import paw_pkg::*; #(
  parameter int TRIANGLES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [6:0]  in_triangle,
  input  logic [3:0]  in_entry_index,
  input  q16_t        in_entry_value,
  input  q16_t        in_target_x1,
  input  q16_t        in_target_y1,
  input  q16_t        in_target_x2,
  input  q16_t        in_target_y2,
  input  q16_t        in_target_x3,
  input  q16_t        in_target_y3,
  input  q16_t        in_point_x,
  input  q16_t        in_point_y,
  output logic        out_valid,
  input  logic        out_stall,
  output q16_t        out_warp_a1,
  output q16_t        out_warp_a2,
  output q16_t        out_warp_a3,
  output q16_t        out_warp_a4,
  output q16_t        out_warp_a5,
  output q16_t        out_warp_a6,
  output q16_t        out_mapped_x,
  output q16_t        out_mapped_y
);

  localparam int NTRI = (TRIANGLES < 128) ? TRIANGLES : 128;
  localparam int TW = (NTRI > 1) ? $clog2(NTRI) : 1;
  localparam int IDEPTH = NTRI * INV_ENTRIES;
  localparam int WDEPTH = NTRI * WARP_ENTRIES;
  localparam int IAW = $clog2(IDEPTH);
  localparam int WAW = $clog2(WDEPTH);

  state_t          state_r, state_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic [2:0]      k_r, k_nxt;
  logic [1:0]      t_r, t_nxt;
  logic            ph_r, ph_nxt;
  mac_ctrl_t       mac_ctrl;

  op_t             op_r;
  logic            tri_ok_r;
  logic [TW-1:0]   tidx_r;
  q16_t            tx_r [3];
  q16_t            ty_r [3];
  q16_t            px_r, py_r;
  q16_t            inv_r [INV_ENTRIES];
  q16_t            old_r [WARP_ENTRIES];
  q16_t            n_r [WARP_ENTRIES];
  q16_t            res_r [WARP_ENTRIES];
  q16_t            mx_r, my_r;
  logic [NTRI-1:0] wv_r;

  logic            accept;
  logic            tri_ok_in;
  logic            row_ok;
  logic            store;
  logic [1:0]      last_t;
  logic [2:0]      last_k;

  logic            inv_we, inv_re;
  logic [IAW-1:0]  inv_waddr, inv_raddr;
  q16_t            inv_q;
  logic            warp_we, warp_re;
  logic [WAW-1:0]  warp_waddr, warp_raddr;
  q16_t            warp_q;

  q16_t            mac_a, mac_b, mac_off, mac_res;
  logic [1:0]      row;
  logic            row1;
  logic [1:0]      col;
  logic [3:0]      cap_i;
  logic [2:0]      cap_w;
  q16_t            warp_val;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign tri_ok_in = (32'(in_triangle) < TRIANGLES);
  assign row_ok    = tri_ok_r && wv_r[tidx_r];

  assign inv_we    = accept && (op_t'(in_opcode) == OP_LOAD) && tri_ok_in &&
                     (in_entry_index < 4'(INV_ENTRIES));
  assign inv_waddr = IAW'(32'(in_triangle) * INV_ENTRIES + 32'(in_entry_index));
  assign inv_re    = (state_r == ST_RD_INV) && (cnt_r < 4'(INV_ENTRIES)) && tri_ok_r;
  assign inv_raddr = IAW'(32'(tidx_r) * INV_ENTRIES + 32'(cnt_r));

  assign warp_re    = (state_r == ST_RD_WARP) && (cnt_r < 4'(WARP_ENTRIES)) && tri_ok_r;
  assign warp_raddr = WAW'(32'(tidx_r) * WARP_ENTRIES + 32'(cnt_r));
  assign warp_we    = (state_r == ST_WR_WARP) && tri_ok_r;
  assign warp_waddr = WAW'(32'(tidx_r) * WARP_ENTRIES + 32'(cnt_r));

  paw_ram #(.WIDTH(32), .DEPTH(IDEPTH)) u_inv_ram (
    .clk   (clk),
    .we    (inv_we),
    .waddr (inv_waddr),
    .wdata (in_entry_value),
    .re    (inv_re),
    .raddr (inv_raddr),
    .rdata (inv_q)
  );

  paw_ram #(.WIDTH(32), .DEPTH(WDEPTH)) u_warp_ram (
    .clk   (clk),
    .we    (warp_we),
    .waddr (warp_waddr),
    .wdata (res_r[cnt_r[2:0]]),
    .re    (warp_re),
    .raddr (warp_raddr),
    .rdata (warp_q)
  );

  paw_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .a      (mac_a),
    .b      (mac_b),
    .offset (mac_off),
    .result (mac_res)
  );

  always_comb begin
    row   = '0;
    row1  = 1'b0;
    col   = '0;
    mac_a = '0;
    mac_b = '0;
    mac_off = '0;
    case (state_r)
      ST_CALC_N: begin
        row   = (k_r >= 3'd3) ? 2'(k_r - 3'd3) : 2'(k_r);
        mac_a = inv_r[4'({2'b0, row} * 4'd3 + {2'b0, t_r})];
        mac_b = (k_r >= 3'd3) ? ty_r[t_r] : tx_r[t_r];
      end
      ST_CALC_W: begin
        row1  = (k_r >= 3'd3);
        col   = 2'(k_r - (row1 ? 3'd3 : 3'd0));
        mac_a = n_r[3'({2'b0, row1} * 3'd3 + {1'b0, t_r})];
        mac_b = old_r[3'({1'b0, t_r} * 3'd3 + {1'b0, col})];
        if (col == 2'd2) begin
          mac_off = row1 ? n_r[5] : n_r[2];
        end
      end
      ST_CALC_M: begin
        mac_a   = old_r[3'({2'b0, k_r[0]} * 3'd3 + {1'b0, t_r})];
        mac_b   = t_r[0] ? py_r : px_r;
        mac_off = k_r[0] ? old_r[5] : old_r[2];
      end
      default: begin
        mac_a = '0;
      end
    endcase
  end

  always_comb begin
    last_t = (state_r == ST_CALC_N) ? 2'd2 : 2'd1;
    last_k = (state_r == ST_CALC_M) ? 3'd1 : 3'd5;
  end

  assign store = ph_r && (t_r == last_t);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      k_r     <= '0;
      t_r     <= '0;
      ph_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      t_r     <= t_nxt;
      ph_r    <= ph_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    t_nxt     = t_r;
    ph_nxt    = ph_r;
    mac_ctrl  = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          k_nxt   = '0;
          t_nxt   = '0;
          ph_nxt  = 1'b0;
          case (op_t'(in_opcode))
            OP_LOAD: state_nxt = ST_DONE;
            OP_MAP:  state_nxt = ST_RD_WARP;
            default: state_nxt = ST_RD_INV;
          endcase
        end
      end
      ST_RD_INV: begin
        if (cnt_r == 4'(INV_ENTRIES)) begin
          cnt_nxt   = '0;
          state_nxt = ST_CALC_N;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      ST_RD_WARP: begin
        if (cnt_r == 4'(WARP_ENTRIES)) begin
          cnt_nxt   = '0;
          state_nxt = (op_r == OP_MAP) ? ST_CALC_M : ST_CALC_W;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      ST_CALC_N, ST_CALC_W, ST_CALC_M: begin
        mac_ctrl.mul  = !ph_r;
        mac_ctrl.init = !ph_r && (t_r == 2'd0);
        mac_ctrl.acc  = ph_r;
        ph_nxt = !ph_r;
        if (ph_r) begin
          if (t_r == last_t) begin
            t_nxt = '0;
            if (k_r == last_k) begin
              k_nxt = '0;
              if (state_r == ST_CALC_N) begin
                state_nxt = (op_r == OP_COMPOSE) ? ST_RD_WARP : ST_WR_WARP;
              end else if (state_r == ST_CALC_W) begin
                state_nxt = ST_WR_WARP;
              end else begin
                state_nxt = ST_DONE;
              end
            end else begin
              k_nxt = k_r + 3'd1;
            end
          end else begin
            t_nxt = t_r + 2'd1;
          end
        end
      end
      ST_WR_WARP: begin
        if (cnt_r == 4'(WARP_ENTRIES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      ST_DONE: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign cap_i    = cnt_r - 4'd1;
  assign cap_w    = 3'(cnt_r - 4'd1);
  assign warp_val = row_ok ? warp_q : ident(cap_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r <= '0;
    end else if (warp_we && (cnt_r == 4'(WARP_ENTRIES - 1))) begin
      wv_r[tidx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= op_t'(in_opcode);
      tri_ok_r <= tri_ok_in;
      tidx_r   <= TW'(in_triangle);
      tx_r[0]  <= in_target_x1;
      tx_r[1]  <= in_target_x2;
      tx_r[2]  <= in_target_x3;
      ty_r[0]  <= in_target_y1;
      ty_r[1]  <= in_target_y2;
      ty_r[2]  <= in_target_y3;
      px_r     <= in_point_x;
      py_r     <= in_point_y;
      mx_r     <= '0;
      my_r     <= '0;
      for (int i = 0; i < WARP_ENTRIES; i++) begin
        res_r[i] <= '0;
      end
    end
    if (state_r == ST_RD_INV && cnt_r != 4'd0) begin
      inv_r[cap_i] <= tri_ok_r ? inv_q : '0;
    end
    if (state_r == ST_RD_WARP && cnt_r != 4'd0) begin
      old_r[cap_w] <= warp_val;
      if (op_r == OP_MAP) begin
        res_r[cap_w] <= warp_val;
      end
    end
    if (store) begin
      case (state_r)
        ST_CALC_N: begin
          n_r[k_r]   <= mac_res;
          res_r[k_r] <= mac_res;
        end
        ST_CALC_W: begin
          res_r[k_r] <= mac_res;
        end
        ST_CALC_M: begin
          if (k_r[0]) begin
            my_r <= mac_res;
          end else begin
            mx_r <= mac_res;
          end
        end
        default: begin
          mx_r <= mx_r;
        end
      endcase
    end
  end

  assign out_warp_a1  = res_r[0];
  assign out_warp_a2  = res_r[1];
  assign out_warp_a3  = res_r[2];
  assign out_warp_a4  = res_r[3];
  assign out_warp_a5  = res_r[4];
  assign out_warp_a6  = res_r[5];
  assign out_mapped_x = mx_r;
  assign out_mapped_y = my_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("engine accepted a request but did not become busy");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("result presented twice");

  a_warp_write_op: assert property (@(posedge clk) disable iff (!rst_n)
    warp_we |-> (op_r == OP_WARP || op_r == OP_COMPOSE))
    else $error("warp table written by a load or map request");

  a_map_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC_M) |-> (op_r == OP_MAP))
    else $error("point mapping entered for a non-map request");

endmodule

// ----- sv/paw_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module paw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/paw_mac.sv -----
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Registered Q16.16 product, floor shift and wide accumulator with saturation.
// ----------------------------------------------------------------------------
module paw_mac import paw_pkg::*; (
  input  logic      clk,
  input  mac_ctrl_t ctrl,
  input  q16_t      a,
  input  q16_t      b,
  input  q16_t      offset,
  output q16_t      result
);

  logic signed [63:0] prod_r;
  acc_t               acc_r;
  acc_t               sum;

  assign sum = acc_r + acc_t'(prod_r >>> 16);
  assign result = sat32(sum);

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod_r <= a * b;
    end
    if (ctrl.init) begin
      acc_r <= acc_t'(offset);
    end else if (ctrl.acc) begin
      acc_r <= sum;
    end
  end

endmodule
